// ===== hdl/rdc_pkg.sv =====
// Shared types, constants and helper functions for the radix digit converter.
// Used by every module in the hdl folder; depends on nothing else.
`timescale 1ns / 1ps

package rdc_pkg;

    // Default sizes, used as the defaults of the top level parameters.
    localparam int STACK_DEPTH_DEF = 32;
    localparam int VALUE_BITS_DEF  = 32;

    // Field widths of the stream items.
    localparam int RADIX_W  = 5;
    localparam int CHAR_W   = 7;
    localparam int STATUS_W = 2;
    localparam int DIGIT_W  = 4;
    localparam int OUT_DATA_W = 8;

    // Quotient bits retired by the shared divider in one cycle.
    localparam int DIV_BITS = 4;

    // Valid radix range.
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    // Character constants.
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DIGIT    = 2'd0,
        ST_NONPOS   = 2'd1,
        ST_BADRADIX = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_POP,
        S_EMIT
    } state_t;

    // Control from the sequencer to the divider, and status back.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // ASCII character for one digit: '0'-'9', then 'A'-'F'.
    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d >= DIGIT_TEN) begin
            ch = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        else begin
            ch = CHAR_ZERO + CHAR_W'(d);
        end
        return ch;
    endfunction

endpackage

// ===== hdl/rdc_divider.sv =====
// Shared iterative divider: divides the running quotient by the radix,
// DIV_BITS quotient bits per cycle, restoring style. Depends on rdc_pkg.
`timescale 1ns / 1ps

module rdc_divider
    import rdc_pkg::*;
#(
    parameter int QUOT_BITS = VALUE_BITS_DEF - 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_ctrl_t            ctrl,
    input  logic [QUOT_BITS-1:0] dividend,
    input  logic [RADIX_W-1:0]   divisor,
    output div_stat_t            stat,
    output logic [QUOT_BITS-1:0] quotient,
    output logic [DIGIT_W-1:0]   remainder
);

    localparam int STEPS = (QUOT_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int PW    = STEPS * DIV_BITS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [PW-1:0]      work_reg, work_next;
    logic [RADIX_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]      cnt_reg;
    logic               done_reg;

    // One cycle of the division: DIV_BITS shift-compare-subtract steps.
    // The partial remainder stays below the divisor, so it fits in 4 bits
    // before each shift.
    always_comb
    begin
        logic [RADIX_W-1:0] r;
        logic [PW-1:0]      w;
        r = rem_reg;
        w = work_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r = {r[RADIX_W-2:0], w[PW-1]};
            w = {w[PW-2:0], 1'b0};
            if (r >= divisor)
            begin
                r    = r - divisor;
                w[0] = 1'b1;
            end
        end
        work_next = w;
        rem_next  = r;
    end

    // Step counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            cnt_reg  <= CW'(STEPS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Dividend / quotient shift register and partial remainder.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            work_reg <= PW'(dividend);
            rem_reg  <= '0;
        end
        else if (cnt_reg != '0)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = work_reg[QUOT_BITS-1:0];
    assign remainder = rem_reg[DIGIT_W-1:0];

endmodule

// ===== hdl/rdc_digit_stack.sv =====
// Digit stack storage: one write port and one read port with registered
// read data. Depends on rdc_pkg.
`timescale 1ns / 1ps

module rdc_digit_stack
    import rdc_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [DIGIT_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [DIGIT_W-1:0] rd_data
);

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/radix_digit_converter_top.sv =====
// Top level of the radix digit converter: stream ports, sequencer, output
// register. Instantiates rdc_divider and rdc_digit_stack; depends on rdc_pkg.
`timescale 1ns / 1ps

// The block takes one item (a signed value and a radix) and returns its digits
// in that radix as ASCII characters, most significant first, with tlast on the
// final digit. A radix outside 2..16 gives one result with status 2, and a
// value of zero or less gives one result with status 1; both carry a zero
// character and tlast. One shared divider produces each digit, retiring four
// quotient bits a cycle while it runs; each digit is pushed onto the stack
// memory, and once the quotient reaches zero the digits are read back and
// loaded into the output register one at a time. The block accepts no item
// until the previous item's digits have all been pushed and popped and the
// output register is empty.
module radix_digit_converter_top
    import rdc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    localparam int IN_W = ((VALUE_BITS + RADIX_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input item.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // value, radix, zero fill
    // Result item.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // digit_char, zero fill
    output logic [STATUS_W-1:0]   m_tuser,   // status
    output logic                  m_tlast
);

    localparam int QB = VALUE_BITS - 1;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int TW = $clog2(STACK_DEPTH + 1);
    localparam logic [TW-1:0] DEPTH_T = TW'(STACK_DEPTH);

    state_t              state_reg, state_next;
    logic [QB-1:0]       quot_reg, quot_next;
    logic [RADIX_W-1:0]  radix_reg, radix_next;
    logic [TW-1:0]       top_reg, top_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    status_t             out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic [VALUE_BITS-1:0] in_value;
    logic [RADIX_W-1:0]    in_radix;
    logic                  bad_radix;
    logic                  non_pos;
    logic                  out_free;

    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;
    logic [QB-1:0]      div_quot;
    logic [DIGIT_W-1:0] div_rem;

    logic               wr_en;
    logic               rd_en;
    logic [TW-1:0]      top_dec;
    logic [DIGIT_W-1:0] rd_data;

    // Input field decode.
    assign in_value  = s_tdata[VALUE_BITS-1:0];
    assign in_radix  = s_tdata[VALUE_BITS +: RADIX_W];
    assign bad_radix = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
    assign non_pos   = in_value[VALUE_BITS-1] || (in_value == '0);
    assign out_free  = !out_valid_reg || m_tready;
    assign top_dec   = top_reg - 1'b1;

    // Shared divider.
    rdc_divider #(
        .QUOT_BITS (QB)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (quot_reg),
        .divisor   (radix_reg),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Digit stack memory.
    rdc_digit_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (top_reg[AW-1:0]),
        .wr_data (div_rem),
        .rd_en   (rd_en),
        .rd_addr (top_dec[AW-1:0]),
        .rd_data (rd_data)
    );

    // Sequencer state and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            quot_reg      <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quot_reg      <= quot_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        radix_reg      <= radix_next;
        out_char_reg   <= out_char_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // Next state and datapath control.
    always_comb
    begin
        state_next      = state_reg;
        quot_next       = quot_reg;
        radix_next      = radix_reg;
        top_next        = top_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_char_next   = out_char_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        div_ctrl.start  = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        s_tready        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = !out_valid_reg;
                if (s_tvalid && !out_valid_reg)
                begin
                    if (bad_radix || non_pos)
                    begin
                        // Single status result, radix check first.
                        out_valid_next  = 1'b1;
                        out_char_next   = '0;
                        out_status_next = bad_radix ? ST_BADRADIX : ST_NONPOS;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        quot_next  = in_value[QB-1:0];
                        radix_next = in_radix;
                        top_next   = '0;
                        state_next = S_DIV_START;
                    end
                end
            end

            S_DIV_START:
            begin
                div_ctrl.start = 1'b1;
                state_next     = S_DIV_WAIT;
            end

            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    // Push the remainder unless the stack is full.
                    if (top_reg < DEPTH_T)
                    begin
                        wr_en    = 1'b1;
                        top_next = top_reg + 1'b1;
                    end
                    quot_next  = div_quot;
                    state_next = (div_quot == '0) ? S_POP : S_DIV_START;
                end
            end

            S_POP:
            begin
                if (out_free)
                begin
                    rd_en      = 1'b1;
                    top_next   = top_dec;
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                out_valid_next  = 1'b1;
                out_char_next   = digit_ascii(rd_data);
                out_status_next = ST_DIGIT;
                out_last_next   = (top_reg == '0);
                state_next      = (top_reg == '0) ? S_IDLE : S_POP;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_char_reg);
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // The divider is idle whenever a new division is started.
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_START) |-> !div_stat.busy)
        else $error("divider started while busy");

    // The stack pointer never passes the stack depth.
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= DEPTH_T)
        else $error("stack pointer beyond depth");

    // A digit is only loaded into an empty output register.
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !out_valid_reg)
        else $error("output register overwritten");

    // Once the final result of an item is shown, the sequencer is idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (state_reg == S_IDLE))
        else $error("final result shown while item still in progress");

    // Status results carry no character and always close the item.
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_DIGIT))
            |-> (out_last_reg && (out_char_reg == '0)))
        else $error("malformed status result");

endmodule

// ===== dv/rdc_checker.sv =====
// Checker for the radix digit converter: watches both stream channels,
// predicts the digit items of each accepted input item and compares them.
// Depends on rdc_pkg for field widths, character constants and status codes.
`timescale 1ns / 1ps

module rdc_checker
    import rdc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    localparam int IN_W = ((VALUE_BITS + RADIX_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // value, radix, zero fill
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // digit_char, zero fill
    input  logic [STATUS_W-1:0]   m_tuser,   // status
    input  logic                  m_tlast,
    output int                    errors,
    output int                    pending
);

    // Limit on printed mismatch lines; every mismatch is still counted.
    localparam int SHOW_MAX = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        status_t           st;
        logic              last;
    } digit_item_t;

    // Digit items still owed by the block, oldest first.
    digit_item_t digits_due[$];
    int          shown = 0;

    // Works out the digit items for one value and radix and queues them.
    task automatic queue_digits(input logic [VALUE_BITS-1:0] value,
                                input logic [RADIX_W-1:0] radix);
        logic [DIGIT_W-1:0]    rem_stack [STACK_DEPTH];
        logic [VALUE_BITS-2:0] quo;
        logic [DIGIT_W-1:0]    d;
        int                    depth;
        digit_item_t           item;
        item.ch   = '0;
        item.last = 1'b1;
        // A bad radix wins over a non-positive value.
        if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            item.st = ST_BADRADIX;
            digits_due.push_back(item);
        end
        else if (value == '0 || value[VALUE_BITS-1]) begin
            item.st = ST_NONPOS;
            digits_due.push_back(item);
        end
        else begin
            // Remainders are stacked least significant first.
            quo   = value[VALUE_BITS-2:0];
            depth = 0;
            while (quo != '0) begin
                if (depth < STACK_DEPTH) begin
                    rem_stack[depth] = DIGIT_W'(quo % radix);
                    depth++;
                end
                quo = quo / radix;
            end
            // Popping gives the most significant digit first.
            while (depth > 0) begin
                depth--;
                d = rem_stack[depth];
                if (d >= DIGIT_TEN)
                    item.ch = CHAR_A + CHAR_W'(d - DIGIT_TEN);
                else
                    item.ch = CHAR_ZERO + CHAR_W'(d);
                item.st   = ST_DIGIT;
                item.last = (depth == 0);
                digits_due.push_back(item);
            end
        end
    endtask

    // Results are checked before new input items are predicted; a result can
    // never belong to an item accepted at the same edge.
    always @(posedge clk) begin : watch
        digit_item_t want;
        logic        wrong;
        if (!rst_n) begin
            errors  <= 0;
            pending <= 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (digits_due.size() == 0) begin
                    errors <= errors + 1;
                    if (shown < SHOW_MAX)
                        $display("%0t: unexpected result: data %h user %h last %b",
                                 $time, m_tdata, m_tuser, m_tlast);
                    shown++;
                end
                else begin
                    want  = digits_due.pop_front();
                    wrong = (m_tdata !== {1'b0, want.ch}) || (m_tuser !== want.st) ||
                            (m_tlast !== want.last);
                    if (wrong) begin
                        errors <= errors + 1;
                        if (shown < SHOW_MAX)
                            $display("%0t: mismatch: expected data %h user %h last %b, %s %h %h %b",
                                     $time, {1'b0, want.ch}, want.st, want.last,
                                     "actual", m_tdata, m_tuser, m_tlast);
                        shown++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                queue_digits(s_tdata[VALUE_BITS-1:0], s_tdata[VALUE_BITS +: RADIX_W]);
            pending <= digits_due.size();
        end
    end

endmodule

// ===== dv/tb_radix_digit_converter_top.sv =====
// Testbench top for the radix digit converter: clock, reset, input items,
// result back-pressure, watchdog and verdict. Depends on rdc_pkg, the block
// radix_digit_converter_top and the checker rdc_checker.
`timescale 1ns / 1ps

module tb_radix_digit_converter_top;
    import rdc_pkg::*;

    localparam int IN_W        = ((VALUE_BITS_DEF + RADIX_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 388;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int BURST_MAX    = 12;
    localparam int GAP_MAX      = 30;

    // Back-pressure patterns of the result side.
    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;

    int   errors;
    int   pending;
    logic hold_armed = 1'b0;
    int   burst_left = 1;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    radix_digit_converter_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    rdc_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    // Offers one item until it is taken; at the end of a burst the valid is
    // dropped for a random gap, otherwise it stays high for the next item.
    task automatic offer(input logic [31:0] value, input logic [RADIX_W-1:0] radix);
        int gap;
        s_tdata  <= IN_W'({radix, value});
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, BURST_MAX);
            gap        = $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stops offering and waits until every owed digit item has come back.
    task automatic drain_digits();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // Random item: mostly positive values of random length in a valid radix,
    // the rest non-positive values or bad radixes.
    task automatic offer_random();
        logic [31:0]        value;
        logic [RADIX_W-1:0] radix;
        int                 pick;
        int                 bits;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            bits  = $urandom_range(1, 31);
            value = $urandom & ((32'd1 << bits) - 32'd1);
            if (value == 32'd0)
                value = 32'd1;
            radix = RADIX_W'($urandom_range(2, 16));
        end
        else if (pick < 90) begin
            value = ($urandom_range(0, 4) == 0) ? 32'd0 : ($urandom | 32'h8000_0000);
            radix = RADIX_W'($urandom_range(0, 31));
        end
        else begin
            value = $urandom;
            radix = RADIX_W'($urandom_range(17, 33));
        end
        offer(value, radix);
    endtask

    // Result side: segments of random back-pressure patterns, and one long
    // hold-off once the stimulus asks for it.
    initial begin : result_side
        rx_mode_t mode;
        int       seg_len;
        logic     hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                mode    = rx_mode_t'($urandom_range(0, 3));
                seg_len = $urandom_range(10, 150);
                repeat (seg_len) begin
                    case (mode)
                        RX_FREE:   m_tready <= 1'b1;
                        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                        default:   m_tready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Ends the run if nothing is accepted on either side for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("status: fail");
        $finish;
    end

    // Stimulus and verdict.
    initial begin : stimulus
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of value and radix, and the special cases.
        offer(32'h7FFF_FFFF, 5'd2);
        offer(32'h7FFF_FFFF, 5'd16);
        offer(32'h7FFF_FFFF, 5'd10);
        offer(32'h0000_0001, 5'd2);
        offer(32'h0000_0001, 5'd16);
        offer(32'h0000_000F, 5'd16);
        offer(32'h0000_000A, 5'd16);
        offer(32'h0000_00FF, 5'd16);
        offer(32'h0000_0010, 5'd16);
        offer(32'h0000_0023, 5'd3);
        offer(32'h1234_5678, 5'd7);
        offer(32'h0000_0002, 5'd2);
        offer(32'h0000_0000, 5'd10);
        offer(32'hFFFF_FFFF, 5'd10);
        offer(32'h8000_0000, 5'd10);
        offer(32'h8000_0000, 5'd2);
        // Bad radix, including a non-positive value where the radix check wins.
        offer(32'h0000_0000, 5'd0);
        offer(32'hFFFF_FFFB, 5'd1);
        offer(32'h0000_0064, 5'd17);
        offer(32'h0000_0064, 5'd31);
        offer(32'h0000_3039, 5'd0);
        offer(32'h7FFF_FFFF, 5'd31);
        drain_digits();

        // Random part, with one long result hold-off and two full drains.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 60)
                hold_armed = 1'b1;
            if (n == 150 || n == 300)
                drain_digits();
            offer_random();
        end
        drain_digits();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
